FILE: rtl/core/fsrt_pkg.sv
// Shared types, constants and helper functions of the foveated shading-rate tile block.
package fsrt_pkg;

  // Tile coordinate width.
  localparam int unsigned COORD_BITS = 12;

  // Datapath widths.
  localparam int unsigned MAG_W  = 32;  // distance magnitude from the subrect centre
  localparam int unsigned AXIS_W = 30;  // ellipse semi-axis, Q.16
  localparam int unsigned NORM_W = 31;  // normalised component, Q.16
  localparam int unsigned RAD_W  = 63;  // sum of squares
  localparam int unsigned ROOT_W = 32;  // distance, Q.16
  localparam int unsigned CMP_W  = 17;  // coordinate compare width

  // Pipeline step counts of the iterative units.
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned RING_STEPS = 19;

  // Side-band line runs from the direction compare to the final mapping.
  localparam int unsigned SIDE_DEPTH = DIV_STEPS + SQRT_STEPS + RING_STEPS + 4;
  localparam int unsigned SIDE_LAST  = SIDE_DEPTH - 1;

  // Fixed-point constants.
  localparam logic [16:0]       SQRT2_Q16  = 17'd92681;
  localparam logic [AXIS_W-1:0] HALF_Q16   = AXIS_W'(32768);
  localparam logic [ROOT_W-1:0] ONE_Q16    = ROOT_W'(65536);
  localparam logic [15:0]       DITHER_Q16 = 16'd9830;
  localparam logic [NORM_W-1:0] NORM_CAP   = {NORM_W{1'b1}};
  localparam logic [15:0]       RING_STEP_MIN   = 16'd3;
  localparam logic [15:0]       RING_STEP_RESET = 16'd256;

  // Rate presets; the remaining code behaves as the default preset.
  localparam logic [1:0] PRESET_FASTER  = 2'd1;
  localparam logic [1:0] PRESET_EXTREME = 2'd2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RATE_PRESET   = 3'd0,
    CFG_DIRECTIONAL   = 3'd1,
    CFG_DITHER        = 3'd2,
    CFG_RING_STEP     = 3'd3,
    CFG_RENDER_WIDTH  = 3'd4,
    CFG_RENDER_HEIGHT = 3'd5,
    CFG_LEFT_SUBRECT  = 3'd6,
    CFG_RIGHT_SUBRECT = 3'd7
  } cfg_idx_e;

  // Output shading levels.
  typedef enum logic [2:0] {
    RL_1X1  = 3'd0,
    RL_2X1  = 3'd1,
    RL_1X2  = 3'd2,
    RL_2X2  = 3'd3,
    RL_4X2  = 3'd4,
    RL_2X4  = 3'd5,
    RL_4X4  = 3'd6,
    RL_CULL = 3'd7
  } rate_level_e;

  // Ring rates before the directional choice.
  typedef enum logic [2:0] {
    RR_FULL    = 3'd0,
    RR_HALF    = 3'd1,
    RR_QUARTER = 3'd2,
    RR_EIGHTH  = 3'd3,
    RR_4X4     = 3'd4,
    RR_CULL    = 3'd5
  } ring_rate_e;

  // Per-tile flags that travel beside the arithmetic.
  typedef struct packed {
    logic cull;
    logic horiz;
    logic par;
  } side_t;

  // Number of rings in the sequence of a preset.
  function automatic logic [2:0] seq_len(input logic [1:0] preset);
    logic [2:0] len;
    priority case (preset)
      PRESET_FASTER:  len = 3'd4;
      PRESET_EXTREME: len = 3'd3;
      default:        len = 3'd6;
    endcase
    return len;
  endfunction

  // Rate of a ring within the sequence of a preset.
  function automatic ring_rate_e seq_rate(input logic [1:0] preset, input logic [2:0] ring);
    ring_rate_e rate;
    rate = RR_CULL;
    priority case (preset)
      PRESET_FASTER: begin
        priority case (ring)
          3'd0:    rate = RR_FULL;
          3'd1:    rate = RR_QUARTER;
          3'd2:    rate = RR_4X4;
          default: rate = RR_CULL;
        endcase
      end
      PRESET_EXTREME: begin
        priority case (ring)
          3'd0:    rate = RR_FULL;
          3'd1:    rate = RR_4X4;
          default: rate = RR_CULL;
        endcase
      end
      default: begin
        priority case (ring)
          3'd0:    rate = RR_FULL;
          3'd1:    rate = RR_HALF;
          3'd2:    rate = RR_QUARTER;
          3'd3:    rate = RR_EIGHTH;
          3'd4:    rate = RR_4X4;
          default: rate = RR_CULL;
        endcase
      end
    endcase
    return rate;
  endfunction

endpackage

FILE: rtl/core/fsrt_norm_div.sv
// Pipelined restoring divider that normalises a distance by an ellipse semi-axis.
module fsrt_norm_div (
  input  logic                             clk_i,
  input  logic [fsrt_pkg::MAG_W-1:0]       mag_i,
  input  logic [fsrt_pkg::AXIS_W-1:0]      axis_i,
  output logic [fsrt_pkg::NORM_W-1:0]      quot_o
);

  // Partial remainder, dividend bits shifting out while quotient bits shift in.
  logic [fsrt_pkg::AXIS_W-1:0] rem_q [fsrt_pkg::DIV_STEPS+1];
  logic [fsrt_pkg::NORM_W-1:0] dq_q  [fsrt_pkg::DIV_STEPS+1];
  logic [fsrt_pkg::AXIS_W-1:0] div_q [fsrt_pkg::DIV_STEPS+1];
  logic                        sat_q [fsrt_pkg::DIV_STEPS+1];

  // Entry stage: the quotient saturates when it would reach bit 31.
  always_ff @(posedge clk_i) begin
    sat_q[0] <= fsrt_pkg::AXIS_W'(mag_i[fsrt_pkg::MAG_W-1:15]) >= axis_i;
    rem_q[0] <= fsrt_pkg::AXIS_W'(mag_i[fsrt_pkg::MAG_W-1:15]);
    dq_q[0]  <= {mag_i[14:0], 16'd0};
    div_q[0] <= axis_i;
  end

  // One quotient bit per stage.
  for (genvar k = 0; k < fsrt_pkg::DIV_STEPS; k++) begin : g_step
    logic [fsrt_pkg::AXIS_W:0]   trial;
    logic                        ge;
    logic [fsrt_pkg::AXIS_W-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k], dq_q[k][fsrt_pkg::NORM_W-1]};
      ge    = trial >= {1'b0, div_q[k]};
      rem_d = ge ? fsrt_pkg::AXIS_W'(trial - {1'b0, div_q[k]})
                 : trial[fsrt_pkg::AXIS_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      dq_q[k+1]  <= {dq_q[k][fsrt_pkg::NORM_W-2:0], ge};
      div_q[k+1] <= div_q[k];
      sat_q[k+1] <= sat_q[k];
    end
  end

  assign quot_o = sat_q[fsrt_pkg::DIV_STEPS] ? fsrt_pkg::NORM_CAP
                                             : dq_q[fsrt_pkg::DIV_STEPS];

endmodule

FILE: rtl/core/fsrt_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module fsrt_isqrt (
  input  logic                        clk_i,
  input  logic [fsrt_pkg::RAD_W-1:0]  rad_i,
  output logic [fsrt_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = fsrt_pkg::ROOT_W + 2;

  logic [REM_W-1:0]            rem_q  [fsrt_pkg::SQRT_STEPS+1];
  logic [fsrt_pkg::ROOT_W-1:0] root_q [fsrt_pkg::SQRT_STEPS+1];
  logic [2*fsrt_pkg::ROOT_W-1:0] rad_q [fsrt_pkg::SQRT_STEPS+1];

  // Entry stage.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    rad_q[0]  <= {1'b0, rad_i};
  end

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar k = 0; k < fsrt_pkg::SQRT_STEPS; k++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_d;

    always_comb begin
      cur   = {rem_q[k], rad_q[k][2*fsrt_pkg::ROOT_W-1 -: 2]};
      trial = {2'b00, root_q[k], 2'b01};
      ge    = cur >= trial;
      rem_d = ge ? REM_W'(cur - trial) : REM_W'(cur);
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= {root_q[k][fsrt_pkg::ROOT_W-2:0], ge};
      rad_q[k+1]  <= {rad_q[k][2*fsrt_pkg::ROOT_W-3:0], 2'b00};
    end
  end

  assign root_o = root_q[fsrt_pkg::SQRT_STEPS];

endmodule

FILE: rtl/core/foveated_shading_rate_tile.sv
// Top level of the foveated shading-rate tile block: per-tile shading level pipeline.
// Throughput: one tile per cycle; busy stays low, as every stage advances each cycle.
// Depth is set by the normalising dividers (31 stages), the square root (32 stages)
// and the ring divider (19 stages), each settling one bit per stage.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
module foveated_shading_rate_tile (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [fsrt_pkg::COORD_BITS-1:0]    tile_x_i,
  input  logic [fsrt_pkg::COORD_BITS-1:0]    tile_y_i,
  output logic                               valid_o,
  output logic [2:0]                         rate_level_o,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [63:0]                        cfg_data_i
);

  localparam int unsigned CB = fsrt_pkg::COORD_BITS;

  // Configuration registers.
  logic [1:0]  rate_preset_q;
  logic        directional_q;
  logic        dither_q;
  logic [15:0] ring_step_q;
  logic [12:0] render_width_q;
  logic [12:0] render_height_q;
  logic [63:0] left_sub_q;
  logic [63:0] right_sub_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_preset_q   <= '0;
      directional_q   <= 1'b0;
      dither_q        <= 1'b0;
      ring_step_q     <= fsrt_pkg::RING_STEP_RESET;
      render_width_q  <= '0;
      render_height_q <= '0;
      left_sub_q      <= '0;
      right_sub_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (fsrt_pkg::cfg_idx_e'(cfg_idx_i))
        fsrt_pkg::CFG_RATE_PRESET:   rate_preset_q   <= cfg_data_i[1:0];
        fsrt_pkg::CFG_DIRECTIONAL:   directional_q   <= cfg_data_i[0];
        fsrt_pkg::CFG_DITHER:        dither_q        <= cfg_data_i[0];
        fsrt_pkg::CFG_RING_STEP:     ring_step_q     <= cfg_data_i[15:0];
        fsrt_pkg::CFG_RENDER_WIDTH:  render_width_q  <= cfg_data_i[12:0];
        fsrt_pkg::CFG_RENDER_HEIGHT: render_height_q <= cfg_data_i[12:0];
        fsrt_pkg::CFG_LEFT_SUBRECT:  left_sub_q      <= cfg_data_i;
        fsrt_pkg::CFG_RIGHT_SUBRECT: right_sub_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a new beat is always taken.
  assign busy = 1'b0;

  logic [11:0] eye_w;
  logic [15:0] step_eff;
  assign eye_w    = render_width_q[12:1];
  assign step_eff = (ring_step_q < fsrt_pkg::RING_STEP_MIN) ? fsrt_pkg::RING_STEP_MIN
                                                            : ring_step_q;

  // Stage 0: input register.
  logic          vld0_q;
  logic [CB-1:0] tx0_q, ty0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    tx0_q <= tile_x_i;
    ty0_q <= tile_y_i;
  end

  // Stage 1: eye selection, area check, centre and half-size products.
  logic [fsrt_pkg::CMP_W-1:0] tx_ext, ty_ext;
  logic        eye1_d, out1_d;
  logic [63:0] sub1;
  logic [17:0] sum_x, sum_y;
  logic        vld1_q, eye1_q, out1_q;
  logic [CB-1:0] tx1_q, ty1_q;
  logic [27:0] half_w1_q;
  logic [28:0] half_h1_q;
  logic [29:0] cxm1_q;
  logic [30:0] cym1_q;

  always_comb begin
    tx_ext = fsrt_pkg::CMP_W'(tx0_q);
    ty_ext = fsrt_pkg::CMP_W'(ty0_q);
    out1_d = (ty_ext >= fsrt_pkg::CMP_W'(render_height_q)) ||
             (tx_ext >= fsrt_pkg::CMP_W'({eye_w, 1'b0}));
    eye1_d = tx_ext >= fsrt_pkg::CMP_W'(eye_w);
    sub1   = eye1_d ? right_sub_q : left_sub_q;
    sum_x  = 18'({sub1[15:0], 1'b0}) + 18'(sub1[47:32]);
    sum_y  = 18'({sub1[31:16], 1'b0}) + 18'(sub1[63:48]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    eye1_q    <= eye1_d;
    out1_q    <= out1_d;
    tx1_q     <= tx0_q;
    ty1_q     <= ty0_q;
    half_w1_q <= 28'(sub1[47:32]) * 28'(eye_w);
    half_h1_q <= 29'(sub1[63:48]) * 29'(render_height_q);
    cxm1_q    <= 30'(sum_x) * 30'(eye_w);
    cym1_q    <= 31'(sum_y) * 31'(render_height_q);
  end

  // Stage 2: semi-axes and distance magnitudes.
  logic [29:0] cx2;
  logic [fsrt_pkg::MAG_W-1:0] posx, posy, cxe, cye;
  logic [44:0] prod_ax;
  logic [45:0] prod_by;
  logic        vld2_q, out2_q, par2_q;
  logic [fsrt_pkg::AXIS_W-1:0] ax2_q, by2_q;
  logic [fsrt_pkg::MAG_W-1:0]  mdx2_q, mdy2_q;
  logic [27:0] half_w2_q;
  logic [28:0] half_h2_q;

  always_comb begin
    cx2     = cxm1_q + (eye1_q ? 30'({eye_w, 16'd0}) : 30'd0);
    posx    = fsrt_pkg::MAG_W'({tx1_q, 16'h8000});
    posy    = fsrt_pkg::MAG_W'({ty1_q, 16'h8000});
    cxe     = fsrt_pkg::MAG_W'(cx2);
    cye     = fsrt_pkg::MAG_W'(cym1_q);
    prod_ax = 45'(half_w1_q) * 45'(fsrt_pkg::SQRT2_Q16);
    prod_by = 46'(half_h1_q) * 46'(fsrt_pkg::SQRT2_Q16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out2_q    <= out1_q;
    par2_q    <= tx1_q[0] ^ ty1_q[0];
    ax2_q     <= fsrt_pkg::AXIS_W'(prod_ax >> 16);
    by2_q     <= fsrt_pkg::AXIS_W'(prod_by >> 16);
    mdx2_q    <= (posx >= cxe) ? posx - cxe : cxe - posx;
    mdy2_q    <= (posy >= cye) ? posy - cye : cye - posy;
    half_w2_q <= half_w1_q;
    half_h2_q <= half_h1_q;
  end

  // Stage 3: degenerate ellipse check and cross products for the direction.
  logic        vld3_q, cull3_q, par3_q;
  logic [60:0] cross_y3_q, cross_x3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cull3_q    <= out2_q || (ax2_q < fsrt_pkg::HALF_Q16) || (by2_q < fsrt_pkg::HALF_Q16);
    par3_q     <= par2_q;
    cross_y3_q <= 61'(mdy2_q) * 61'(half_w2_q);
    cross_x3_q <= 61'(mdx2_q) * 61'(half_h2_q);
  end

  // Normalised components, in parallel with stage 3 onwards.
  logic [fsrt_pkg::NORM_W-1:0] nx, ny;

  fsrt_norm_div u_div_x (
    .clk_i  (clk_i),
    .mag_i  (mdx2_q),
    .axis_i (ax2_q),
    .quot_o (nx)
  );

  fsrt_norm_div u_div_y (
    .clk_i  (clk_i),
    .mag_i  (mdy2_q),
    .axis_i (by2_q),
    .quot_o (ny)
  );

  // Side-band line: flags and valid bits wait for the arithmetic.
  fsrt_pkg::side_t side_q     [fsrt_pkg::SIDE_DEPTH];
  logic            side_vld_q [fsrt_pkg::SIDE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q[0] <= 1'b0;
    end else begin
      side_vld_q[0] <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{cull: cull3_q, horiz: cross_y3_q < cross_x3_q, par: par3_q};
  end

  for (genvar k = 1; k < fsrt_pkg::SIDE_DEPTH; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_vld_q[k] <= 1'b0;
      end else begin
        side_vld_q[k] <= side_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Squares, then their sum.
  logic [2*fsrt_pkg::NORM_W-1:0] sq_x_q, sq_y_q;
  logic [fsrt_pkg::RAD_W-1:0]    rad_q;

  always_ff @(posedge clk_i) begin
    sq_x_q <= (2*fsrt_pkg::NORM_W)'(nx) * (2*fsrt_pkg::NORM_W)'(nx);
    sq_y_q <= (2*fsrt_pkg::NORM_W)'(ny) * (2*fsrt_pkg::NORM_W)'(ny);
    rad_q  <= fsrt_pkg::RAD_W'(sq_x_q) + fsrt_pkg::RAD_W'(sq_y_q);
  end

  // Elliptical distance.
  logic [fsrt_pkg::ROOT_W-1:0] ell_dist;

  fsrt_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad_q),
    .root_o (ell_dist)
  );

  // Ring divider: (d - 1.0) << 8 divided by the ring step, one bit per stage.
  logic [15:0]                 rg_rem_q [fsrt_pkg::RING_STEPS+1];
  logic [fsrt_pkg::RING_STEPS-1:0] rg_dq_q [fsrt_pkg::RING_STEPS+1];
  logic                        rg_sat_q [fsrt_pkg::RING_STEPS+1];
  logic                        rg_le1_q [fsrt_pkg::RING_STEPS+1];
  logic [fsrt_pkg::ROOT_W-1:0] dist_m1;

  assign dist_m1 = ell_dist - fsrt_pkg::ONE_Q16;

  always_ff @(posedge clk_i) begin
    rg_le1_q[0] <= ell_dist <= fsrt_pkg::ONE_Q16;
    rg_sat_q[0] <= fsrt_pkg::ROOT_W'(dist_m1[fsrt_pkg::ROOT_W-1:11]) >=
                   fsrt_pkg::ROOT_W'(step_eff);
    rg_rem_q[0] <= dist_m1[26:11];
    rg_dq_q[0]  <= {dist_m1[10:0], 8'd0};
  end

  for (genvar k = 0; k < fsrt_pkg::RING_STEPS; k++) begin : g_ring
    logic [16:0] trial;
    logic        ge;

    always_comb begin
      trial = {rg_rem_q[k], rg_dq_q[k][fsrt_pkg::RING_STEPS-1]};
      ge    = trial >= {1'b0, step_eff};
    end

    always_ff @(posedge clk_i) begin
      rg_rem_q[k+1] <= ge ? 16'(trial - {1'b0, step_eff}) : trial[15:0];
      rg_dq_q[k+1]  <= {rg_dq_q[k][fsrt_pkg::RING_STEPS-2:0], ge};
      rg_sat_q[k+1] <= rg_sat_q[k];
      rg_le1_q[k+1] <= rg_le1_q[k];
    end
  end

  // Final stage: ring index, dither, preset sequence and direction.
  fsrt_pkg::side_t        side_f;
  logic [fsrt_pkg::RING_STEPS-1:0] outer;
  logic [2:0]             len, last;
  logic [3:0]             ring;
  fsrt_pkg::ring_rate_e   rate;
  fsrt_pkg::rate_level_e  level_d;
  logic                   vert_pick;

  always_comb begin
    side_f = side_q[fsrt_pkg::SIDE_LAST];
    outer  = rg_dq_q[fsrt_pkg::RING_STEPS];
    len    = fsrt_pkg::seq_len(rate_preset_q);
    last   = len - 3'd1;
    if (rg_le1_q[fsrt_pkg::RING_STEPS]) begin
      ring = 4'd0;
    end else if (rg_sat_q[fsrt_pkg::RING_STEPS]) begin
      ring = 4'(last);
    end else begin
      ring = 4'(outer[18:16]) + 4'd1;
      if (dither_q && (ring < 4'(last)) && (outer[15:0] < fsrt_pkg::DITHER_Q16) &&
          side_f.par) begin
        ring = ring - 4'd1;
      end
    end
    if (ring > 4'(last)) begin
      ring = 4'(last);
    end
    rate      = fsrt_pkg::seq_rate(rate_preset_q, ring[2:0]);
    vert_pick = directional_q && !side_f.horiz;
    unique case (rate)
      fsrt_pkg::RR_FULL:    level_d = fsrt_pkg::RL_1X1;
      fsrt_pkg::RR_HALF:    level_d = vert_pick ? fsrt_pkg::RL_1X2 : fsrt_pkg::RL_2X1;
      fsrt_pkg::RR_QUARTER: level_d = fsrt_pkg::RL_2X2;
      fsrt_pkg::RR_EIGHTH:  level_d = vert_pick ? fsrt_pkg::RL_2X4 : fsrt_pkg::RL_4X2;
      fsrt_pkg::RR_4X4:     level_d = fsrt_pkg::RL_4X4;
      default:              level_d = fsrt_pkg::RL_CULL;
    endcase
    if (side_f.cull) begin
      level_d = fsrt_pkg::RL_CULL;
    end
  end

  // Output register: one beat per strobe.
  logic       valid_q;
  logic [2:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_vld_q[fsrt_pkg::SIDE_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign valid_o      = valid_q;
  assign rate_level_o = level_q;

  // A culled tile always leaves as cull.
  a_cull_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_vld_q[fsrt_pkg::SIDE_LAST] && side_q[fsrt_pkg::SIDE_LAST].cull) |=>
      (valid_o && rate_level_o == fsrt_pkg::RL_CULL))
    else $error("culled tile did not leave as cull");

  // A tile inside the unit ellipse that is not culled gets full rate.
  a_inner_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_vld_q[fsrt_pkg::SIDE_LAST] && !side_q[fsrt_pkg::SIDE_LAST].cull &&
     rg_le1_q[fsrt_pkg::RING_STEPS]) |=> (rate_level_o == fsrt_pkg::RL_1X1))
    else $error("tile inside the inner ellipse did not get full rate");

  // A vertical variant is only chosen for a tile that is not horizontal.
  a_vertical_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (rate_level_o == fsrt_pkg::RL_1X2 || rate_level_o == fsrt_pkg::RL_2X4)) |->
      !$past(side_q[fsrt_pkg::SIDE_LAST].horiz))
    else $error("vertical rate chosen for a horizontal tile");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the foveated shading-rate tile block.
`timescale 1ns / 1ps

module tb_top;
  import fsrt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 120;

  typedef struct {
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
  } tile_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_BITS-1:0] tile_x_i = '0;
  logic [COORD_BITS-1:0] tile_y_i = '0;
  logic                  valid_o;
  logic [2:0]            rate_level_o;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_idx_i = '0;
  logic [63:0]           cfg_data_i = '0;

  // Shadow copy of the configuration registers.
  logic [1:0]  sh_preset;
  logic        sh_directional;
  logic        sh_dither;
  logic [15:0] sh_ring_step;
  logic [12:0] sh_width;
  logic [12:0] sh_height;
  logic [63:0] sh_left;
  logic [63:0] sh_right;

  tile_t       pending_tiles[$];
  rate_level_e expected_levels[$];
  int unsigned send_idle_pct = 19;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  foveated_shading_rate_tile u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .tile_x_i     (tile_x_i),
    .tile_y_i     (tile_y_i),
    .valid_o      (valid_o),
    .rate_level_o (rate_level_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Shading level of one tile under the shadow configuration.
  function automatic rate_level_e shade_level(input logic [COORD_BITS-1:0] tx_in,
                                              input logic [COORD_BITS-1:0] ty_in);
    logic [63:0] tx, ty, eye_w, eye, sub, ux, uy, uw, uh, cx, cy;
    logic [63:0] half_w, half_h, ax, by, px, py, mdx, mdy, nx, ny, d, step, outer, ring;
    logic [63:0] len;
    logic        horiz;
    ring_rate_e  rate;
    tx = 64'(tx_in);
    ty = 64'(ty_in);
    eye_w = 64'(sh_width >> 1);
    if (ty >= 64'(sh_height) || tx >= 2 * eye_w) return RL_CULL;
    eye = (tx >= eye_w) ? 64'd1 : 64'd0;
    sub = eye[0] ? sh_right : sh_left;
    ux = 64'(sub[15:0]);
    uy = 64'(sub[31:16]);
    uw = 64'(sub[47:32]);
    uh = 64'(sub[63:48]);
    cx = ((eye * eye_w) << 16) + (2 * ux + uw) * eye_w;
    cy = (2 * uy + uh) * 64'(sh_height);
    half_w = uw * eye_w;
    half_h = uh * 64'(sh_height);
    ax = (half_w * 64'd92681) >> 16;
    by = (half_h * 64'd92681) >> 16;
    if (ax < 64'd32768 || by < 64'd32768) return RL_CULL;
    px = (tx << 16) + 64'd32768;
    py = (ty << 16) + 64'd32768;
    mdx = (px >= cx) ? px - cx : cx - px;
    mdy = (py >= cy) ? py - cy : cy - py;
    nx = (mdx << 16) / ax;
    ny = (mdy << 16) / by;
    if (nx > 64'h7FFF_FFFF) nx = 64'h7FFF_FFFF;
    if (ny > 64'h7FFF_FFFF) ny = 64'h7FFF_FFFF;
    d = int_sqrt(nx * nx + ny * ny);
    len = (sh_preset == 2'd1) ? 64'd4 : (sh_preset == 2'd2) ? 64'd3 : 64'd6;
    if (d <= 64'd65536) begin
      ring = 0;
    end else begin
      step = (sh_ring_step < 16'd3) ? 64'd3 : 64'(sh_ring_step);
      outer = ((d - 64'd65536) << 8) / step;
      ring = 1 + (outer >> 16);
      // Checkerboard dither pulls odd tiles just past a boundary one ring inward.
      if (sh_dither && ring < len - 1 && outer[15:0] < 16'd9830 && tx[0] ^ ty[0])
        ring = ring - 1;
    end
    if (ring >= len) ring = len - 1;
    rate = seq_rate(sh_preset, ring[2:0]);
    horiz = (mdy * half_w) < (mdx * half_h);
    case (rate)
      RR_FULL:    return RL_1X1;
      RR_HALF:    return (sh_directional && !horiz) ? RL_1X2 : RL_2X1;
      RR_QUARTER: return RL_2X2;
      RR_EIGHTH:  return (sh_directional && !horiz) ? RL_2X4 : RL_4X2;
      RR_4X4:     return RL_4X4;
      default:    return RL_CULL;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: presents the oldest pending tile, holding it until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_levels.push_back(shade_level(tile_x_i, tile_y_i));
        void'(pending_tiles.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_tiles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start    <= 1'b1;
          tile_x_i <= pending_tiles[0].tx;
          tile_y_i <= pending_tiles[0].ty;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", rate_level_o));
        end else begin
          if (rate_level_o !== expected_levels[0])
            report_mismatch($sformatf("rate_level got %0d want %0d",
                                      rate_level_o, expected_levels[0]));
          void'(expected_levels.pop_front());
        end
      end
      if (valid_o || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("foveated_shading_rate_tile regression: fail");
        $finish;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_RATE_PRESET:   sh_preset = data[1:0];
      CFG_DIRECTIONAL:   sh_directional = data[0];
      CFG_DITHER:        sh_dither = data[0];
      CFG_RING_STEP:     sh_ring_step = data[15:0];
      CFG_RENDER_WIDTH:  sh_width = data[12:0];
      CFG_RENDER_HEIGHT: sh_height = data[12:0];
      CFG_LEFT_SUBRECT:  sh_left = data;
      default:           sh_right = data;
    endcase
  endtask

  task automatic configure(input logic [1:0] preset, input logic dir, input logic dith,
                           input logic [15:0] rstep, input logic [12:0] w,
                           input logic [12:0] h, input logic [63:0] left,
                           input logic [63:0] right);
    cfg_write(CFG_RATE_PRESET, 64'(preset));
    cfg_write(CFG_DIRECTIONAL, 64'(dir));
    cfg_write(CFG_DITHER, 64'(dith));
    cfg_write(CFG_RING_STEP, 64'(rstep));
    cfg_write(CFG_RENDER_WIDTH, 64'(w));
    cfg_write(CFG_RENDER_HEIGHT, 64'(h));
    cfg_write(CFG_LEFT_SUBRECT, left);
    cfg_write(CFG_RIGHT_SUBRECT, right);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_tile(input int unsigned x, input int unsigned y);
    tile_t t;
    t.tx = x[COORD_BITS-1:0];
    t.ty = y[COORD_BITS-1:0];
    pending_tiles.push_back(t);
  endtask

  // Lets the queued tiles run out and every result drain before the next phase.
  task automatic drain;
    while (pending_tiles.size() > 0 || expected_levels.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_subrect();
    logic [63:0] s;
    if ($urandom_range(9) == 0) begin
      s = {$urandom, $urandom};
    end else begin
      s[15:0]  = 16'($urandom_range(16'h6000));
      s[31:16] = 16'($urandom_range(16'h6000));
      s[47:32] = 16'($urandom_range(16'h8000, 16'h0800));
      s[63:48] = 16'($urandom_range(16'h8000, 16'h0800));
    end
    return s;
  endfunction

  localparam logic [63:0] CENTRED = {16'h4000, 16'h4000, 16'h2000, 16'h2000};

  initial begin
    int unsigned w, h;
    logic [15:0] rstep;
    sh_preset = 2'd0;
    sh_directional = 1'b0;
    sh_dither = 1'b0;
    sh_ring_step = RING_STEP_RESET;
    sh_width = '0;
    sh_height = '0;
    sh_left = '0;
    sh_right = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: zero width culls everything.
    add_tile(0, 0);
    add_tile(4095, 4095);
    drain();

    // Corners, edges and the centre of a small area.
    configure(2'd0, 1'b1, 1'b1, 16'd64, 13'd64, 13'd32, CENTRED, CENTRED);
    add_tile(0, 0);
    add_tile(63, 31);
    add_tile(64, 0);
    add_tile(0, 32);
    add_tile(16, 16);
    add_tile(48, 16);
    add_tile(17, 16);
    add_tile(16, 2);
    add_tile(4095, 4095);
    drain();

    // Odd width leaves the last column outside both eyes.
    configure(2'd1, 1'b0, 1'b0, 16'd0, 13'd65, 13'd40, CENTRED, CENTRED);
    add_tile(64, 5);
    add_tile(63, 5);
    add_tile(3, 39);
    drain();

    // Degenerate left ellipse, extreme ring step and top of the area size.
    configure(2'd2, 1'b1, 1'b0, 16'hFFFF, 13'd4096, 13'd4096, 64'd0, CENTRED);
    add_tile(10, 10);
    add_tile(2048, 0);
    add_tile(4095, 4095);
    add_tile(3000, 2000);
    drain();

    // Width below two and the preset that acts as the default.
    configure(2'd3, 1'b1, 1'b1, 16'd3, 13'd1, 13'd4096, CENTRED, CENTRED);
    add_tile(0, 0);
    add_tile(0, 100);
    drain();

    for (int p = 0; p < 12; p++) begin
      send_idle_pct = (p < 4) ? 19 : (p < 8) ? 52 : 0;
      w = ($urandom_range(7) == 0) ? $urandom_range(4096) : $urandom_range(300, 2);
      h = ($urandom_range(7) == 0) ? $urandom_range(4096) : $urandom_range(300, 1);
      case ($urandom_range(3))
        0:       rstep = 16'($urandom_range(2));
        1:       rstep = 16'hFFFF - 16'($urandom_range(3));
        default: rstep = 16'($urandom_range(1024, 3));
      endcase
      configure(2'($urandom), 1'($urandom), 1'($urandom), rstep, 13'(w), 13'(h),
                rand_subrect(), rand_subrect());
      for (int i = 0; i < 95; i++) begin
        if ($urandom_range(9) == 0) add_tile($urandom_range(4095), $urandom_range(4095));
        else add_tile($urandom_range(w + 1), $urandom_range(h + 1));
      end
      drain();
    end

    if (error_count == 0) begin
      $display("foveated_shading_rate_tile regression: pass");
    end else begin
      $display("foveated_shading_rate_tile regression: fail");
    end
    $finish;
  end

endmodule
